### sv/pru_pkg.sv
// Shared types and constants for the pixel replication upscaler.
// Used by every module of the block; depends on nothing else.
package pru_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned DEF_MAX_SCALE = 16;
  localparam int unsigned DEF_QDEPTH    = 4;

  localparam int unsigned PIX_W      = 24;
  localparam int unsigned SCALE_REG_W = 5;
  localparam int unsigned WIDTH_REG_W = 11;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 11;

  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH = 2'd1;

  localparam logic OP_PIXEL  = 1'b0;
  localparam logic OP_REPLAY = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             is_pad;
    logic             row_end;
    logic             last;
    logic             error;
  } out_t;

  // One classified item handed from the front end to the emitter.
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [1:0]       pad;
    logic             row_done;
    logic             err;
  } cmd_t;

endpackage

### sv/pru_front.sv
// Front end: accepts items, checks the kind against the row phase, keeps the
// line buffer and column/pass counters, and pushes commands. Uses pru_pkg.
module pru_front #(
  parameter int unsigned MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_SCALE = pru_pkg::DEF_MAX_SCALE,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned SW = $clog2(MAX_SCALE + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [WW-1:0]   w_eff,
  input  logic [SW-1:0]   s_eff,
  input  logic            in_valid,
  output logic            in_ready,
  input  pru_pkg::in_t    in_data,
  output logic            push,
  output pru_pkg::cmd_t   push_cmd,
  input  logic            q_ready
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned PW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic [pru_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];

  logic [AW-1:0]  column_r, column_nxt;
  logic [PW-1:0]  row_pass_r, row_pass_nxt;
  logic           stage_valid_r;
  logic           stage_replay_r;
  logic [pru_pkg::PIX_W-1:0] stage_pix_r;
  logic [pru_pkg::PIX_W-1:0] rdata_r;
  logic [1:0]     stage_pad_r;
  logic           stage_done_r;
  logic           stage_err_r;

  logic           accept;
  logic           err;
  logic           row_done;
  logic [1:0]     pad;
  logic [1:0]     pad_prod;
  logic           wr_en;
  logic           rd_en;

  assign in_ready = !stage_valid_r || q_ready;
  assign accept   = in_valid && in_ready;
  assign push     = stage_valid_r && q_ready;

  assign err      = (in_data.operation == pru_pkg::OP_PIXEL) != (row_pass_r == '0);
  assign row_done = (WW'(column_r) + WW'(1)) >= w_eff;
  // Only the low two bits of width and scale decide the row's byte count mod 4.
  assign pad_prod = 2'(w_eff) * 2'(s_eff);
  assign pad      = row_done ? pad_prod : 2'd0;
  assign wr_en    = accept && !err && (in_data.operation == pru_pkg::OP_PIXEL);
  assign rd_en    = accept && !err && (in_data.operation == pru_pkg::OP_REPLAY);

  always_comb begin
    column_nxt   = column_r;
    row_pass_nxt = row_pass_r;
    if (accept && !err) begin
      if (row_done) begin
        column_nxt = '0;
        if ((SW'(row_pass_r) + SW'(1)) >= s_eff) begin
          row_pass_nxt = '0;
        end else begin
          row_pass_nxt = row_pass_r + PW'(1);
        end
      end else begin
        column_nxt = column_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[column_r] <= in_data.pixel;
    end
    if (rd_en) begin
      rdata_r <= line_mem[column_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r      <= '0;
      row_pass_r    <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      column_r   <= column_nxt;
      row_pass_r <= row_pass_nxt;
      if (accept) begin
        stage_valid_r <= 1'b1;
      end else if (push) begin
        stage_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_replay_r <= in_data.operation == pru_pkg::OP_REPLAY;
      stage_pix_r    <= in_data.pixel;
      stage_pad_r    <= err ? 2'd0 : pad;
      stage_done_r   <= !err && row_done;
      stage_err_r    <= err;
    end
  end

  always_comb begin
    push_cmd.value    = stage_err_r ? '0 : (stage_replay_r ? rdata_r : stage_pix_r);
    push_cmd.pad      = stage_pad_r;
    push_cmd.row_done = stage_done_r;
    push_cmd.err      = stage_err_r;
  end

endmodule

### sv/pru_queue.sv
// Short command FIFO between the front end and the emitter.
// Uses pru_pkg for the command type.
module pru_queue #(
  parameter int unsigned DEPTH = pru_pkg::DEF_QDEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pru_pkg::cmd_t push_cmd,
  output logic          q_ready,
  input  logic          pop,
  output logic          q_valid,
  output pru_pkg::cmd_t q_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pru_pkg::cmd_t       entry_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  assign q_ready = count_r != CNT_W'(DEPTH);
  assign q_valid = count_r != '0;
  assign q_cmd   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_W'(DEPTH)) && !pop |-> !push)
    else $error("command pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !pop)
    else $error("command popped from an empty queue");
`endif

endmodule

### sv/pru_back.sv
// Emitter: expands each command into replicated pixels, padding bytes or
// one error result, one result per cycle while out_ready is high and commands wait. Uses pru_pkg.
module pru_back #(
  parameter int unsigned MAX_SCALE = pru_pkg::DEF_MAX_SCALE,
  localparam int unsigned SW = $clog2(MAX_SCALE + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [SW-1:0] s_eff,
  input  logic          q_valid,
  input  pru_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output pru_pkg::out_t out_data
);

  logic          cur_valid_r;
  pru_pkg::cmd_t cur_r;
  logic [SW-1:0] px_left_r;
  logic [1:0]    pad_left_r;

  logic          fin;
  logic          is_pad;
  logic          take;

  assign is_pad = px_left_r == '0;
  assign fin    = ((px_left_r == SW'(1)) && (pad_left_r == 2'd0)) ||
                  (is_pad && (pad_left_r == 2'd1));
  assign take   = cur_valid_r && out_ready;
  assign pop    = q_valid && (!cur_valid_r || (take && fin));

  assign out_valid = cur_valid_r;
  always_comb begin
    out_data.value   = is_pad ? '0 : cur_r.value;
    out_data.is_pad  = is_pad;
    out_data.row_end = fin && cur_r.row_done;
    out_data.last    = fin;
    out_data.error   = cur_r.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
    end else if (take && fin) begin
      cur_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r      <= q_cmd;
      // An error result is a single non-pad transfer with a zero value.
      px_left_r  <= q_cmd.err ? SW'(1) : s_eff;
      pad_left_r <= q_cmd.pad;
    end else if (take) begin
      if (!is_pad) begin
        px_left_r <= px_left_r - SW'(1);
      end else begin
        pad_left_r <= pad_left_r - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.last && !out_data.is_pad &&
                                    !out_data.row_end && (out_data.value == '0))
    else $error("error result is not a single zero transfer");
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_pad |-> (out_data.value == '0) && !out_data.error)
    else $error("padding byte carries data");
  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_end |-> out_data.last)
    else $error("row end on a transfer that is not the last of its item");
`endif

endmodule

### sv/pixel_replication_upscaler_unit.sv
// Pixel replication upscaler, top level: configuration registers and wiring.
// Items pass the front-end stage register, the queue and the emitter register.
// Throughput: one result per cycle while out_ready is high; results per item are
// scale plus padding, one if rejected; one item accepted per cycle while q_ready.
// Reset (rst_n, synchronous, active low) clears counters, queue and config to
// scale 1, width 1; the line buffer is not cleared.
module pixel_replication_upscaler_unit #(
  parameter int unsigned MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_SCALE = pru_pkg::DEF_MAX_SCALE,
  parameter int unsigned QDEPTH    = pru_pkg::DEF_QDEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pru_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pru_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pru_pkg::out_t                  out_data
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SW = $clog2(MAX_SCALE + 1);

  logic [pru_pkg::SCALE_REG_W-1:0] scale_r;
  logic [pru_pkg::WIDTH_REG_W-1:0] width_r;
  logic [SW-1:0] s_eff;
  logic [WW-1:0] w_eff;

  logic          push;
  pru_pkg::cmd_t push_cmd;
  logic          q_ready;
  logic          q_valid;
  pru_pkg::cmd_t q_cmd;
  logic          pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= pru_pkg::SCALE_REG_W'(1);
      width_r <= pru_pkg::WIDTH_REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pru_pkg::CFG_SCALE: scale_r <= cfg_wdata[pru_pkg::SCALE_REG_W-1:0];
        pru_pkg::CFG_WIDTH: width_r <= cfg_wdata[pru_pkg::WIDTH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped to the supported range.
  always_comb begin
    if (scale_r == '0) begin
      s_eff = SW'(1);
    end else if (32'(scale_r) > MAX_SCALE) begin
      s_eff = SW'(MAX_SCALE);
    end else begin
      s_eff = SW'(scale_r);
    end
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
  end

  pru_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .w_eff    (w_eff),
    .s_eff    (s_eff),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready)
  );

  pru_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  pru_back #(
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_eff     (s_eff),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/pixel_replication_upscaler_unit_tb.sv
// Self-checking testbench for pixel_replication_upscaler_unit: a scoreboard class
// predicts every output transfer, and tasks drive the pixel, replay and register ports.
// Depends on pru_pkg and on the upscaler RTL, nothing else.

class replica_checker;
  logic [pru_pkg::PIX_W-1:0] line_store [pru_pkg::DEF_MAX_WIDTH];
  bit written [pru_pkg::DEF_MAX_WIDTH];
  int unsigned column, row_pass, scale_reg, width_reg;
  pru_pkg::out_t queued_beats [$];
  int unsigned mismatches, items, beats, err_beats, pad_beats, row_ends;

  function new();
    column = 0;
    row_pass = 0;
    scale_reg = 1;
    width_reg = 1;
    mismatches = 0;
    items = 0;
    beats = 0;
    err_beats = 0;
    pad_beats = 0;
    row_ends = 0;
  endfunction

  function int unsigned clamp_scale(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > pru_pkg::DEF_MAX_SCALE) return pru_pkg::DEF_MAX_SCALE;
    return raw;
  endfunction

  function int unsigned clamp_width(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > pru_pkg::DEF_MAX_WIDTH) return pru_pkg::DEF_MAX_WIDTH;
    return raw;
  endfunction

  function void write_reg(logic [pru_pkg::CFG_ADDR_W-1:0] addr,
                          logic [pru_pkg::CFG_DATA_W-1:0] data);
    if (addr == pru_pkg::CFG_SCALE) scale_reg = 32'(data[pru_pkg::SCALE_REG_W-1:0]);
    else if (addr == pru_pkg::CFG_WIDTH) width_reg = 32'(data);
  endfunction

  function bit replay_ok();
    return written[column % pru_pkg::DEF_MAX_WIDTH];
  endfunction

  // True when every column below w has been stored since reset.
  function bit store_covers(int unsigned w);
    int unsigned c;
    for (c = 0; c < w; c++) begin
      if (!written[c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function int unsigned pending();
    return queued_beats.size();
  endfunction

  function void queue_beat(logic [pru_pkg::PIX_W-1:0] v, bit pad, bit rend, bit lst,
                           bit err);
    pru_pkg::out_t b;
    b.value = v;
    b.is_pad = pad;
    b.row_end = rend;
    b.last = lst;
    b.error = err;
    queued_beats.push_back(b);
  endfunction

  function void note_accepted(pru_pkg::in_t item);
    int unsigned s, w, col, pad, i;
    logic [pru_pkg::PIX_W-1:0] v;
    bit done, fin;
    items++;
    s = clamp_scale(scale_reg);
    w = clamp_width(width_reg);
    col = column % pru_pkg::DEF_MAX_WIDTH;
    // A pixel during a repeat pass, or a replay during the first pass, is rejected.
    if ((item.operation == pru_pkg::OP_PIXEL) != (row_pass == 0)) begin
      queue_beat('0, 1'b0, 1'b0, 1'b1, 1'b1);
      return;
    end
    if (item.operation == pru_pkg::OP_PIXEL) begin
      line_store[col] = item.pixel;
      written[col] = 1'b1;
      v = item.pixel;
    end else begin
      v = line_store[col];
    end
    done = (column + 1 >= w);
    pad = done ? (4 - ((w * s * 3) & 3)) & 3 : 0;
    for (i = 0; i < s; i++) begin
      fin = (i + 1 == s) && (pad == 0);
      queue_beat(v, 1'b0, fin && done, fin, 1'b0);
    end
    for (i = 0; i < pad; i++) begin
      fin = (i + 1 == pad);
      queue_beat('0, 1'b1, fin, fin, 1'b0);
    end
    if (done) begin
      column = 0;
      row_pass = (row_pass + 1 >= s) ? 0 : row_pass + 1;
    end else begin
      column++;
    end
  endfunction

  task flag_mismatch(string msg);
    if (mismatches < 40) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task check_result(pru_pkg::out_t got);
    pru_pkg::out_t want;
    beats++;
    if (queued_beats.size() == 0) begin
      flag_mismatch($sformatf("transfer %0d not expected: value=%h pad=%b end=%b last=%b err=%b",
                              beats, got.value, got.is_pad, got.row_end, got.last, got.error));
      return;
    end
    want = queued_beats.pop_front();
    if (want.error) err_beats++;
    if (want.is_pad) pad_beats++;
    if (want.row_end) row_ends++;
    if (got.value !== want.value || got.is_pad !== want.is_pad ||
        got.row_end !== want.row_end || got.last !== want.last ||
        got.error !== want.error) begin
      flag_mismatch($sformatf(
        "transfer %0d: got value=%h pad=%b end=%b last=%b err=%b, want %h %b %b %b %b",
        beats, got.value, got.is_pad, got.row_end, got.last, got.error,
        want.value, want.is_pad, want.row_end, want.last, want.error));
    end
  endtask
endclass

module pixel_replication_upscaler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned RANDOM_PHASES = 12;

  typedef enum int unsigned {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [pru_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [pru_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  pru_pkg::in_t                   in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  pru_pkg::out_t                  out_data;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles = 0;
  int unsigned settings_used = 1;
  replica_checker sb = new();

  pixel_replication_upscaler_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("pixel_replication_upscaler_unit_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  function automatic void set_idle(idle_mode_t m);
    case (m)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 85; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 85; end
      default:       begin send_idle_pct = 7;  stall_pct = 7;  end
    endcase
  endfunction

  task automatic send_item(logic op, logic [pru_pkg::PIX_W-1:0] pix);
    pru_pkg::in_t item;
    item.operation = op;
    item.pixel = pix;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (!in_ready);
    sb.note_accepted(item);
  endtask

  // Holds the input side low until every predicted transfer has arrived.
  task automatic drain(int unsigned extra);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_cfg(logic [pru_pkg::CFG_ADDR_W-1:0] addr,
                           logic [pru_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(addr, data);
  endtask

  function automatic logic [pru_pkg::CFG_DATA_W-1:0] pick_scale();
    int unsigned r, v;
    r = $urandom_range(99);
    if (r < 70) v = $urandom_range(1, 4);
    else if (r < 85) v = $urandom_range(5, pru_pkg::DEF_MAX_SCALE);
    else if (r < 93) v = $urandom_range(pru_pkg::DEF_MAX_SCALE + 1, 31);
    else v = 0;
    return v[pru_pkg::CFG_DATA_W-1:0];
  endfunction

  function automatic logic [pru_pkg::CFG_DATA_W-1:0] pick_width();
    int unsigned r, v;
    r = $urandom_range(99);
    if (r < 65) v = $urandom_range(1, 8);
    else if (r < 80) v = $urandom_range(9, 48);
    else if (r < 86) v = 0;
    else if (r < 92) v = pru_pkg::DEF_MAX_WIDTH;
    else v = $urandom_range(pru_pkg::DEF_MAX_WIDTH + 1, 2047);
    return v[pru_pkg::CFG_DATA_W-1:0];
  endfunction

  function automatic pru_pkg::in_t next_item();
    pru_pkg::in_t item;
    logic [31:0] r;
    r = $urandom();
    item.pixel = r[pru_pkg::PIX_W-1:0];
    if ($urandom_range(99) < 15) item.pixel = $urandom_range(1) ? '1 : '0;
    if (sb.row_pass == 0) item.operation = pru_pkg::OP_PIXEL;
    else if (sb.replay_ok()) item.operation = pru_pkg::OP_REPLAY;
    else item.operation = pru_pkg::OP_PIXEL;
    // About a tenth of the transfers are of the wrong kind for the current pass.
    if ($urandom_range(99) < 10)
      item.operation = (sb.row_pass == 0) ? pru_pkg::OP_REPLAY : pru_pkg::OP_PIXEL;
    return item;
  endfunction

  task automatic run_phase(idle_mode_t mode, bit hold_midway);
    logic [pru_pkg::CFG_DATA_W-1:0] new_width;
    int unsigned count, k;
    pru_pkg::in_t item;
    drain(DRAIN_CYCLES);
    write_cfg(pru_pkg::CFG_SCALE, pick_scale());
    new_width = pick_width();
    // Widening the row during a repeat pass would replay columns never stored.
    if (sb.row_pass == 0 || sb.store_covers(sb.clamp_width(32'(new_width))))
      write_cfg(pru_pkg::CFG_WIDTH, new_width);
    settings_used++;
    set_idle(mode);
    count = $urandom_range(22, 38);
    for (k = 0; k < count; k++) begin
      if (hold_midway && k == count / 2) drain(0);
      item = next_item();
      send_item(item.operation, item.pixel);
    end
  endtask

  initial begin
    int unsigned phase;
    set_idle(IDLE_NONE);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings, one pixel per row: extreme pixels and a rejected replay.
    send_item(pru_pkg::OP_PIXEL, 24'h000000);
    send_item(pru_pkg::OP_PIXEL, 24'hFFFFFF);
    send_item(pru_pkg::OP_REPLAY, 24'h5A5A5A);

    // Zero in both registers behaves as one.
    drain(DRAIN_CYCLES);
    write_cfg(pru_pkg::CFG_SCALE, '0);
    write_cfg(pru_pkg::CFG_WIDTH, '0);
    settings_used++;
    send_item(pru_pkg::OP_PIXEL, 24'hA5A5A5);
    send_item(pru_pkg::OP_REPLAY, 24'h000000);

    // Values above the maximum saturate.
    drain(DRAIN_CYCLES);
    write_cfg(pru_pkg::CFG_SCALE, 11'd31);
    write_cfg(pru_pkg::CFG_WIDTH, 11'd2047);
    settings_used++;
    send_item(pru_pkg::OP_PIXEL, 24'h123456);
    send_item(pru_pkg::OP_PIXEL, 24'hFFFFFF);
    send_item(pru_pkg::OP_REPLAY, 24'h000000);

    // Shrink the row below the current column, then the pass count below the current pass.
    drain(DRAIN_CYCLES);
    write_cfg(pru_pkg::CFG_WIDTH, 11'd1);
    settings_used++;
    send_item(pru_pkg::OP_PIXEL, 24'h800001);
    send_item(pru_pkg::OP_REPLAY, 24'hFFFFFF);
    send_item(pru_pkg::OP_PIXEL, 24'h0F0F0F);
    drain(DRAIN_CYCLES);
    write_cfg(pru_pkg::CFG_SCALE, 11'd2);
    settings_used++;
    send_item(pru_pkg::OP_REPLAY, 24'h000000);

    // One complete three by three block.
    drain(DRAIN_CYCLES);
    write_cfg(pru_pkg::CFG_SCALE, 11'd3);
    write_cfg(pru_pkg::CFG_WIDTH, 11'd3);
    settings_used++;
    send_item(pru_pkg::OP_PIXEL, 24'h010203);
    send_item(pru_pkg::OP_PIXEL, 24'hFEDCBA);
    send_item(pru_pkg::OP_PIXEL, 24'h7F7F80);
    repeat (6) send_item(pru_pkg::OP_REPLAY, 24'h000000);

    for (phase = 0; phase < RANDOM_PHASES; phase++)
      run_phase(idle_mode_t'(phase % 4), phase == 2);

    drain(DRAIN_CYCLES);
    if (sb.pending() != 0)
      sb.flag_mismatch($sformatf("%0d expected transfers never arrived", sb.pending()));
    $display("Run covered %0d input transfers and %0d output transfers over %0d settings.",
             sb.items, sb.beats, settings_used);
    $display("These held %0d rejected items, %0d padding bytes and %0d output row ends.",
             sb.err_beats, sb.pad_beats, sb.row_ends);
    if (sb.mismatches == 0) begin
      $display("pixel_replication_upscaler_unit_tb OK");
    end else begin
      $display("pixel_replication_upscaler_unit_tb NOT OK");
    end
    $finish;
  end
endmodule
